FILE: design/bls_pkg.sv
// Shared types, widths and codes for the Bresenham line stepper.
`default_nettype none

package bls_pkg;

  localparam int COORD_BITS = 12;
  localparam int DELTA_W    = COORD_BITS + 1;
  localparam int ERR_W      = COORD_BITS + 4;
  localparam int CLIP_W     = 12;
  localparam int COLOR_W    = 32;
  localparam int CMP_W      = (COORD_BITS > CLIP_W) ? COORD_BITS : CLIP_W;

  // Stream payload layout
  localparam int IN_FIELDS_W = 4 * COORD_BITS;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * COORD_BITS + COLOR_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W  = 2;
  localparam int TUSER_PIXEL_VALID  = 0;
  localparam int TUSER_WRITE_ENABLE = 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_X_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_Y_MIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_X_MAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_Y_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR = 3'd4;

  // Input item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DELTA_W-1:0]    delta_t;
  typedef logic signed [ERR_W-1:0]      err_t;
  typedef logic [CLIP_W-1:0]            clip_t;
  typedef logic [COLOR_W-1:0]           color_t;

endpackage

`default_nettype wire

FILE: design/bresenham_line_stepper.sv
// Bresenham line stepper: line setup, per-pixel stepping, clip test and output register.
//
// Usage: a beat on the s_axis side with tuser = 0 loads a line from the two
// endpoints in tdata; a beat with tuser = 1 asks for the next pixel. Every
// input beat produces exactly one m_axis beat. A load beat and a step with no
// line loaded give an all-zero beat; a step on an active line gives the pixel
// coordinates, the clip-rectangle write enable and the draw color, with tlast
// on the final pixel of the line, after which the line is no longer active.
// Each output beat is registered and comes out in the cycle after its input
// beat. Throughput is one beat per cycle while the receiver keeps up: the line
// setup and the error-term update are each one add/compare path between the
// line state and output registers, so consecutive steps issue back to back.
// The cfg channel writes the clip edges and the color; it is always ready and
// must be used only while no beat is in flight.
// Reset clears the line state (no line loaded), sets the clip window to the
// full 0..4095 range and the color to zero, and empties the output register.
// When the receiver stalls, the output register holds its beat and s_axis
// tready drops until that beat is taken; no beat is lost or repeated.
`default_nettype none

module bresenham_line_stepper import bls_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // input stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // x_start, y_start, x_end, y_end
  input  logic                   s_axis_tuser_i,  // kind
  // output stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // pixel_x, pixel_y, pixel_color
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o,  // pixel_valid, write_enable
  output logic                   m_axis_tlast_o   // last
);

  // configuration registers
  clip_t  clip_x_min_q, clip_y_min_q, clip_x_max_q, clip_y_max_q;
  color_t draw_color_q;

  // line state
  logic   line_active_q;
  logic   y_major_q;
  coord_t major_pos_q, minor_pos_q, major_stop_q;
  delta_t major_delta_q, minor_delta_q;
  logic   minor_step_neg_q;
  err_t   error_term_q;

  // output register
  logic   out_valid_q;
  coord_t out_x_q, out_y_q;
  color_t out_color_q;
  logic   out_pv_q, out_we_q, out_last_q;

  logic s_fire;
  logic cfg_fire;

  assign cfg_ready_o     = 1'b1;
  assign cfg_fire        = cfg_valid_i & cfg_ready_o;
  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_x_min_q <= '0;
      clip_y_min_q <= '0;
      clip_x_max_q <= '1;
      clip_y_max_q <= '1;
      draw_color_q <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        CFG_CLIP_X_MIN: clip_x_min_q <= cfg_data_i[CLIP_W-1:0];
        CFG_CLIP_Y_MIN: clip_y_min_q <= cfg_data_i[CLIP_W-1:0];
        CFG_CLIP_X_MAX: clip_x_max_q <= cfg_data_i[CLIP_W-1:0];
        CFG_CLIP_Y_MAX: clip_y_max_q <= cfg_data_i[CLIP_W-1:0];
        CFG_DRAW_COLOR: draw_color_q <= cfg_data_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- line setup ----------------
  coord_t in_x0, in_y0, in_x1, in_y1;
  delta_t ld_dx, ld_dy, ld_adx, ld_ady;
  logic   ld_y_major, ld_swap, ld_neg;
  coord_t ld_a0, ld_b0, ld_a1, ld_b1;
  coord_t ld_major_pos, ld_minor_pos, ld_major_stop, ld_minor_end;
  delta_t ld_major_delta, ld_minor_delta;
  err_t   ld_two_minor, ld_error;

  assign in_x0 = $signed(s_axis_tdata_i[0*COORD_BITS +: COORD_BITS]);
  assign in_y0 = $signed(s_axis_tdata_i[1*COORD_BITS +: COORD_BITS]);
  assign in_x1 = $signed(s_axis_tdata_i[2*COORD_BITS +: COORD_BITS]);
  assign in_y1 = $signed(s_axis_tdata_i[3*COORD_BITS +: COORD_BITS]);

  always_comb begin
    ld_dx  = DELTA_W'(in_x1) - DELTA_W'(in_x0);
    ld_dy  = DELTA_W'(in_y1) - DELTA_W'(in_y0);
    ld_adx = ld_dx[DELTA_W-1] ? -ld_dx : ld_dx;
    ld_ady = ld_dy[DELTA_W-1] ? -ld_dy : ld_dy;
    ld_y_major = ld_adx < ld_ady;
    ld_a0 = ld_y_major ? in_y0 : in_x0;
    ld_b0 = ld_y_major ? in_x0 : in_y0;
    ld_a1 = ld_y_major ? in_y1 : in_x1;
    ld_b1 = ld_y_major ? in_x1 : in_y1;
    // order endpoints so the major coordinate rises
    ld_swap       = ld_a1 < ld_a0;
    ld_major_pos  = ld_swap ? ld_a1 : ld_a0;
    ld_major_stop = ld_swap ? ld_a0 : ld_a1;
    ld_minor_pos  = ld_swap ? ld_b1 : ld_b0;
    ld_minor_end  = ld_swap ? ld_b0 : ld_b1;
    ld_major_delta = DELTA_W'(ld_major_stop) - DELTA_W'(ld_major_pos);
    ld_minor_delta = DELTA_W'(ld_minor_end) - DELTA_W'(ld_minor_pos);
    ld_neg        = ld_minor_delta[DELTA_W-1];
    ld_two_minor  = ERR_W'(ld_minor_delta) <<< 1;
    // error = 2*dminor - s*dmajor
    ld_error = ld_neg ? ld_two_minor + ERR_W'(ld_major_delta)
                      : ld_two_minor - ERR_W'(ld_major_delta);
  end

  // ---------------- stepping ----------------
  logic   st_fin, st_err_pos, st_take;
  err_t   st_two_major, st_err_adj, st_error;
  coord_t st_minor_pos, st_px, st_py;
  logic   st_inside;
  logic [CMP_W-1:0] st_px_u, st_py_u;

  always_comb begin
    st_fin       = major_pos_q >= major_stop_q;
    st_err_pos   = ~error_term_q[ERR_W-1] & (error_term_q != '0);
    // s*error > 0 rule, mirrored for negative minor direction
    st_take      = minor_step_neg_q ? error_term_q[ERR_W-1] : st_err_pos;
    st_two_major = ERR_W'(major_delta_q) <<< 1;
    if (!st_take) begin
      st_err_adj   = error_term_q;
      st_minor_pos = minor_pos_q;
    end else if (minor_step_neg_q) begin
      st_err_adj   = error_term_q + st_two_major;
      st_minor_pos = minor_pos_q - coord_t'(1);
    end else begin
      st_err_adj   = error_term_q - st_two_major;
      st_minor_pos = minor_pos_q + coord_t'(1);
    end
    st_error = st_err_adj + (ERR_W'(minor_delta_q) <<< 1);

    st_px   = y_major_q ? minor_pos_q : major_pos_q;
    st_py   = y_major_q ? major_pos_q : minor_pos_q;
    st_px_u = CMP_W'(unsigned'(st_px));
    st_py_u = CMP_W'(unsigned'(st_py));
    // negative coordinates always fall outside the unsigned clip window
    st_inside = ~st_px[COORD_BITS-1] & ~st_py[COORD_BITS-1]
              & (st_px_u >= CMP_W'(clip_x_min_q)) & (st_px_u <= CMP_W'(clip_x_max_q))
              & (st_py_u >= CMP_W'(clip_y_min_q)) & (st_py_u <= CMP_W'(clip_y_max_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_active_q    <= 1'b0;
      y_major_q        <= 1'b0;
      major_pos_q      <= '0;
      minor_pos_q      <= '0;
      major_stop_q     <= '0;
      major_delta_q    <= '0;
      minor_delta_q    <= '0;
      minor_step_neg_q <= 1'b0;
      error_term_q     <= '0;
    end else if (s_fire) begin
      if (s_axis_tuser_i == KIND_LOAD) begin
        line_active_q    <= 1'b1;
        y_major_q        <= ld_y_major;
        major_pos_q      <= ld_major_pos;
        minor_pos_q      <= ld_minor_pos;
        major_stop_q     <= ld_major_stop;
        major_delta_q    <= ld_major_delta;
        minor_delta_q    <= ld_minor_delta;
        minor_step_neg_q <= ld_neg;
        error_term_q     <= ld_error;
      end else if (line_active_q) begin
        if (st_fin) begin
          line_active_q <= 1'b0;
        end else begin
          major_pos_q  <= major_pos_q + coord_t'(1);
          minor_pos_q  <= st_minor_pos;
          error_term_q <= st_error;
        end
      end
    end
  end

  // ---------------- output register ----------------
  logic pix_valid_d;
  assign pix_valid_d = (s_axis_tuser_i == KIND_STEP) & line_active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_pv_q    <= pix_valid_d;
      out_x_q     <= pix_valid_d ? st_px : '0;
      out_y_q     <= pix_valid_d ? st_py : '0;
      out_we_q    <= pix_valid_d & st_inside;
      out_color_q <= pix_valid_d ? draw_color_q : '0;
      out_last_q  <= pix_valid_d & st_fin;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_color_q, out_y_q, out_x_q});
  assign m_axis_tlast_o  = out_last_q;
  always_comb begin
    m_axis_tuser_o = '0;
    m_axis_tuser_o[TUSER_PIXEL_VALID]  = out_pv_q;
    m_axis_tuser_o[TUSER_WRITE_ENABLE] = out_we_q;
  end

`ifndef NO_ASSERTIONS
  // a load always leaves an active line behind it
  a_load_activates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser_i == KIND_LOAD) |=> line_active_q)
    else $error("line not active after load");

  // the final pixel retires the line
  a_last_retires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && pix_valid_d && st_fin |=> !line_active_q && out_last_q)
    else $error("line still active after final pixel");

  // write enable and last only ride on a real pixel
  a_flags_need_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_we_q || out_last_q) |-> out_pv_q)
    else $error("write enable or last without pixel");

  // a stalled result is never dropped
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q)
    else $error("output beat dropped under stall");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/bresenham_line_stepper_tb.sv
// Self-checking testbench for the Bresenham line stepper: directed table, then random lines.
`timescale 1ns / 100ps

module bresenham_line_stepper_tb;
  import bls_pkg::*;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int IDLE_PCT        = 18;
  localparam int HOLD_CYCLES     = 80;
  localparam int DRAIN_PAD       = 3;
  localparam int STALL_LIMIT     = 1000;
  localparam int PAD_W           = CFG_DATA_W - CLIP_W;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_DRAW_COLOR + 1'b1;

  typedef struct packed {
    logic   valid;
    logic   wen;
    logic   fin;
    coord_t x;
    coord_t y;
    color_t color;
  } pixel_t;

  typedef struct packed {
    logic   kind;
    int     xs;
    int     ys;
    int     xe;
    int     ye;
    bit     typed;
    pixel_t want;
  } row_t;

  localparam pixel_t BLANK = '0;

  // Opening table: typed rows are loads, steps with no line, and the single-point line.
  localparam row_t PLAN [25] = '{
    '{KIND_STEP, 0, 0, 0, 0, 1'b1, BLANK},
    '{KIND_LOAD, -2048, -2048, -2048, -2048, 1'b1, BLANK},
    '{KIND_STEP, 0, 0, 0, 0, 1'b1,
      '{1'b1, 1'b0, 1'b1, coord_t'(-2048), coord_t'(-2048), color_t'(0)}},
    '{KIND_STEP, 2047, -1, -2048, 1, 1'b1, BLANK},
    '{KIND_LOAD, 0, 0, 3, 1, 1'b1, BLANK},
    '{KIND_STEP, 0, 0, 0, 0, 1'b0, BLANK},
    '{KIND_STEP, 0, 0, 0, 0, 1'b0, BLANK},
    '{KIND_STEP, 0, 0, 0, 0, 1'b0, BLANK},
    '{KIND_STEP, 0, 0, 0, 0, 1'b0, BLANK},
    '{KIND_LOAD, 2047, 0, 2044, 3, 1'b1, BLANK},
    '{KIND_STEP, 0, 0, 0, 0, 1'b0, BLANK},
    '{KIND_STEP, 0, 0, 0, 0, 1'b0, BLANK},
    '{KIND_STEP, 0, 0, 0, 0, 1'b0, BLANK},
    '{KIND_STEP, 0, 0, 0, 0, 1'b0, BLANK},
    '{KIND_LOAD, 5, 2047, 4, 2043, 1'b1, BLANK},
    '{KIND_STEP, 0, 0, 0, 0, 1'b0, BLANK},
    '{KIND_STEP, 0, 0, 0, 0, 1'b0, BLANK},
    '{KIND_STEP, 0, 0, 0, 0, 1'b0, BLANK},
    '{KIND_LOAD, -2048, -2048, 2047, 2047, 1'b1, BLANK},
    '{KIND_STEP, 0, 0, 0, 0, 1'b0, BLANK},
    '{KIND_STEP, 0, 0, 0, 0, 1'b0, BLANK},
    '{KIND_LOAD, 10, 7, 8, 7, 1'b1, BLANK},
    '{KIND_STEP, 0, 0, 0, 0, 1'b0, BLANK},
    '{KIND_STEP, 0, 0, 0, 0, 1'b0, BLANK},
    '{KIND_STEP, 0, 0, 0, 0, 1'b0, BLANK}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   s_axis_tuser_i = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [OUT_TUSER_W-1:0] m_axis_tuser_o;
  logic                   m_axis_tlast_o;

  bresenham_line_stepper dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // line tracker state and shadow registers
  bit     drawing, steep, rise_down;
  int     run_pos, rise_pos, run_end, run_len, rise_len, slack;
  int     clip_xlo = 0, clip_ylo = 0, clip_xhi = 4095, clip_yhi = 4095;
  color_t shade = '0;

  pixel_t pixel_q [$];
  int     errors = 0;
  int     beats_seen = 0;
  int     hold_left = 0;
  bit     no_gaps = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic pixel_t next_pixel(input logic kind, input coord_t xs, input coord_t ys,
                                        input coord_t xe, input coord_t ye);
    pixel_t px;
    int x0, y0, x1, y1, a0, b0, a1, b1, tmp, sgn, px_x, px_y;
    px = '0;
    x0 = xs;
    y0 = ys;
    x1 = xe;
    y1 = ye;
    if (kind == KIND_LOAD) begin
      steep = ((x1 >= x0) ? x1 - x0 : x0 - x1) < ((y1 >= y0) ? y1 - y0 : y0 - y1);
      if (steep) begin
        a0 = y0; b0 = x0; a1 = y1; b1 = x1;
      end else begin
        a0 = x0; b0 = y0; a1 = x1; b1 = y1;
      end
      if (a1 < a0) begin
        tmp = a0; a0 = a1; a1 = tmp;
        tmp = b0; b0 = b1; b1 = tmp;
      end
      run_pos   = a0;
      rise_pos  = b0;
      run_end   = a1;
      run_len   = a1 - a0;
      rise_len  = b1 - b0;
      rise_down = rise_len < 0;
      sgn       = rise_down ? -1 : 1;
      slack     = 2 * rise_len - sgn * run_len;
      drawing   = 1'b1;
    end else if (drawing) begin
      px_x     = steep ? rise_pos : run_pos;
      px_y     = steep ? run_pos : rise_pos;
      px.valid = 1'b1;
      px.x     = coord_t'(px_x);
      px.y     = coord_t'(px_y);
      px.wen   = px_x >= clip_xlo && px_x <= clip_xhi && px_y >= clip_ylo && px_y <= clip_yhi;
      px.color = shade;
      px.fin   = run_pos >= run_end;
      if (px.fin) begin
        drawing = 1'b0;
      end else begin
        sgn = rise_down ? -1 : 1;
        // mirrored error rule keeps negative slopes landing on their endpoint
        if (sgn * slack > 0) begin
          slack    -= 2 * sgn * run_len;
          rise_pos += sgn;
        end
        slack   += 2 * rise_len;
        run_pos += 1;
      end
    end
    return px;
  endfunction

  function automatic coord_t clamp_coord(input int v);
    if (v > 2047) return coord_t'(2047);
    if (v < -2048) return coord_t'(-2048);
    return coord_t'(v);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CLIP_X_MIN: clip_xlo = int'(data[CLIP_W-1:0]);
      CFG_CLIP_Y_MIN: clip_ylo = int'(data[CLIP_W-1:0]);
      CFG_CLIP_X_MAX: clip_xhi = int'(data[CLIP_W-1:0]);
      CFG_CLIP_Y_MAX: clip_yhi = int'(data[CLIP_W-1:0]);
      CFG_DRAW_COLOR: shade = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_item(input logic kind, input coord_t xs, input coord_t ys,
                           input coord_t xe, input coord_t ye, input bit typed,
                           input pixel_t want);
    pixel_t pred;
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= IN_TDATA_W'({ye, xe, ys, xs});
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = next_pixel(kind, xs, ys, xe, ye);
    pixel_q.push_back(typed ? want : pred);
  endtask

  // stop offering beats and let every expected pixel come out
  task automatic drain_pixels();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on output beat %0d: %s got %0h, expected %0h", beats_seen, what, got, want);
    errors++;
  endtask

  task automatic check_pixel_beat();
    pixel_t want, got;
    got.valid = m_axis_tuser_o[TUSER_PIXEL_VALID];
    got.wen   = m_axis_tuser_o[TUSER_WRITE_ENABLE];
    got.fin   = m_axis_tlast_o;
    got.x     = m_axis_tdata_o[COORD_BITS-1:0];
    got.y     = m_axis_tdata_o[2*COORD_BITS-1:COORD_BITS];
    got.color = m_axis_tdata_o[2*COORD_BITS +: COLOR_W];
    if (pixel_q.size() == 0) begin
      note_mismatch("beat with nothing pending", 1, 0);
    end else begin
      want = pixel_q.pop_front();
      if (got.valid !== want.valid) note_mismatch("pixel_valid", got.valid, want.valid);
      if (got.wen !== want.wen) note_mismatch("write_enable", got.wen, want.wen);
      if (got.fin !== want.fin) note_mismatch("last", got.fin, want.fin);
      if (got.x !== want.x) note_mismatch("pixel_x", got.x, want.x);
      if (got.y !== want.y) note_mismatch("pixel_y", got.y, want.y);
      if (got.color !== want.color) note_mismatch("pixel_color", got.color, want.color);
    end
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      check_pixel_beat();
      beats_seen++;
      if (beats_seen == 250 || beats_seen == 700) hold_left = HOLD_CYCLES;
    end
  end

  // pixel sink: random back-pressure plus long holds that fill the stepper
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int     phase, sent, n, len, dx, dy, roll, xlo, ylo, xhi, yhi;
    bit     paused;
    coord_t xs, ys, xe, ye;
    color_t hue;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (PLAN[i]) begin
      send_item(PLAN[i].kind, coord_t'(PLAN[i].xs), coord_t'(PLAN[i].ys),
                coord_t'(PLAN[i].xe), coord_t'(PLAN[i].ye), PLAN[i].typed, PLAN[i].want);
    end
    drain_pixels();

    for (phase = 1; phase <= PHASES; phase++) begin
      case (phase)
        1: begin  // empty window on both axes
          xlo = 4095; ylo = 4095; xhi = 0; yhi = 0; hue = '1;
        end
        2: begin
          xlo = 0; ylo = 0; xhi = 4095; yhi = 4095; hue = '0;
        end
        3: begin  // single-pixel window near the origin
          xlo = $urandom_range(0, 31); xhi = xlo;
          ylo = $urandom_range(0, 31); yhi = ylo;
          hue = $urandom;
        end
        default: begin
          xlo = $urandom_range(0, 2047); xhi = xlo + $urandom_range(0, 2048);
          ylo = $urandom_range(0, 2047); yhi = ylo + $urandom_range(0, 2048);
          hue = $urandom;
        end
      endcase
      no_gaps = (phase == 4);
      // upper data bits are junk; only the low clip bits should stick
      write_reg(CFG_CLIP_X_MIN, {PAD_W'($urandom), clip_t'(xlo)});
      write_reg(CFG_CLIP_Y_MIN, {PAD_W'($urandom), clip_t'(ylo)});
      write_reg(CFG_CLIP_X_MAX, {PAD_W'($urandom), clip_t'(xhi)});
      write_reg(CFG_CLIP_Y_MAX, {PAD_W'($urandom), clip_t'(yhi)});
      write_reg(CFG_DRAW_COLOR, hue);
      write_reg(CFG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 2)), $urandom);

      sent = 0;
      paused = 1'b0;
      while (sent < ITEMS_PER_PHASE) begin
        if (!paused && sent >= ITEMS_PER_PHASE / 2) begin
          drain_pixels();
          paused = 1'b1;
        end
        roll = $urandom_range(99);
        if (roll < 20) begin
          send_item(logic'($urandom_range(1)), coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), coord_t'($urandom), 1'b0, BLANK);
          sent++;
        end else begin
          if ($urandom_range(3) == 0) begin
            // start around the origin so lines cross the clip edges and go negative
            xs = coord_t'(int'($urandom_range(0, 96)) - 16);
            ys = coord_t'(int'($urandom_range(0, 96)) - 16);
          end else begin
            xs = coord_t'($urandom);
            ys = coord_t'($urandom);
          end
          if (roll < 25) begin
            xe = coord_t'($urandom);
            ye = coord_t'($urandom);
          end else begin
            dx = int'($urandom_range(0, 32)) - 16;
            dy = int'($urandom_range(0, 32)) - 16;
            case ($urandom_range(9))
              0: dx = 0;
              1: dy = 0;
              2: begin dx = 0; dy = 0; end
              default: ;
            endcase
            xe = clamp_coord(int'(xs) + dx);
            ye = clamp_coord(int'(ys) + dy);
          end
          dx = int'(xe) - int'(xs);
          dy = int'(ye) - int'(ys);
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          len = (dx > dy) ? dx : dy;
          n = len + 1;
          roll = $urandom_range(99);
          if (roll < 12) n += $urandom_range(1, 3);
          else if (roll < 22) n = $urandom_range(0, len);
          if (n > 48) n = $urandom_range(1, 48);
          send_item(KIND_LOAD, xs, ys, xe, ye, 1'b0, BLANK);
          repeat (n) begin
            send_item(KIND_STEP, coord_t'($urandom), coord_t'($urandom),
                      coord_t'($urandom), coord_t'($urandom), 1'b0, BLANK);
          end
          sent += n + 1;
        end
      end
      drain_pixels();
    end

    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
design/bls_pkg.sv
design/bresenham_line_stepper.sv
tb/sv/bresenham_line_stepper_tb.sv
